// File: rtl/core/dds_pkg.sv
// Shared constants and codes for the dependency-counting dataflow scheduler.
package dds_pkg;

  localparam int DEF_MAX_OPS     = 256;
  localparam int DEF_MAX_SUCC    = 8;
  localparam int DEF_MAX_WORKERS = 16;

  localparam int KIND_W    = 2;
  localparam int OP_W      = 8;
  localparam int DEP_W     = 8;
  localparam int STOT_W    = 4;
  localparam int SLOT_W    = 3;
  localparam int STATUS_W  = 8;
  localparam int DONE_W    = 9;
  localparam int WORKERS_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 9;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_OP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SUCC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE  = 2'd2;

  // result kinds
  localparam logic OUT_READY = 1'b0;
  localparam logic OUT_STOP  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_OPS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 1'd1;

  localparam logic [DONE_W-1:0]    TOTAL_OPS_RESET    = 9'd1;
  localparam logic [WORKERS_W-1:0] WORKER_COUNT_RESET = 5'd3;

endpackage

// File: rtl/core/dag_dependency_scheduler_core.sv
// Top level of the dependency-counting dataflow scheduler.
// A load request (kind 0 or 1) is taken without raising busy, so loads can
// arrive every cycle; an operation loaded with zero dependencies shows up as a ready
// result in the next cycle. A completion keeps busy high through the successor walk
// and, when it ends the run, through the stop markers: the successor walk performs one
// read-modify-write of the operation memory per cycle, behind a table read and a pending
// count read that run ahead in a short pipeline. Results come one per cycle on strobe and
// cannot be held off; the final result of a request carries last. Entries of the operation
// and successor memories must be loaded before a completion refers to them.
module dag_dependency_scheduler_core #(
  parameter int MAX_OPS     = dds_pkg::DEF_MAX_OPS,
  parameter int MAX_SUCC    = dds_pkg::DEF_MAX_SUCC,
  parameter int MAX_WORKERS = dds_pkg::DEF_MAX_WORKERS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dds_pkg::KIND_W-1:0]     kind,
  input  logic [dds_pkg::OP_W-1:0]       op_index,
  input  logic [dds_pkg::DEP_W-1:0]      initial_dependencies,
  input  logic [dds_pkg::STOT_W-1:0]     successor_total,
  input  logic [dds_pkg::SLOT_W-1:0]     successor_slot,
  input  logic [dds_pkg::OP_W-1:0]       successor_op,
  input  logic [dds_pkg::STATUS_W-1:0]   kernel_status,
  output logic                           strobe,
  output logic                           out_kind,
  output logic [dds_pkg::OP_W-1:0]       ready_op,
  output logic [dds_pkg::STATUS_W-1:0]   run_status,
  output logic                           last,
  input  logic                           cfg_write,
  input  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dds_pkg::CFG_W-1:0]      cfg_data
);
  import dds_pkg::*;

  localparam int OPW    = $clog2(MAX_OPS);
  localparam int SW     = (MAX_SUCC > 1) ? $clog2(MAX_SUCC) : 1;
  localparam int CW     = $clog2(MAX_SUCC + 1);
  localparam int WKW    = $clog2(MAX_WORKERS + 1);
  localparam int TDEPTH = MAX_OPS * (2 ** SW);

  typedef struct packed {
    logic [DEP_W-1:0] pending;
    logic [CW-1:0]    succ;
  } op_entry_t;

  typedef enum logic [2:0] {S_IDLE, S_CNT, S_WALK, S_STOP, S_FLUSH} state_t;

  state_t state;

  // memories
  op_entry_t         op_mem [MAX_OPS];
  logic [OP_W-1:0]   tab_mem [TDEPTH];
  op_entry_t         op_rdata;
  logic [OP_W-1:0]   tab_rdata;

  logic              op_rd_en, op_we, tab_rd_en, tab_we;
  logic [OPW-1:0]    op_rd_addr, op_wr_addr;
  op_entry_t         op_wr_data;
  logic [OPW+SW-1:0] tab_rd_addr, tab_wr_addr;

  // control and status registers
  logic [DONE_W-1:0]    op_goal;
  logic [WORKERS_W-1:0] worker_cnt;
  logic [DONE_W-1:0]    done_count;
  logic [STATUS_W-1:0]  failure_code;
  logic                 halted;
  logic                 end_run;
  logic [OPW-1:0]       cur_op;
  logic [CW-1:0]        cnt, issue_idx;
  logic                 tvalid, pvalid;
  logic [OPW-1:0]       p_addr;
  logic                 wr_valid_q;
  logic [OPW-1:0]       wr_addr_q;
  op_entry_t            wr_data_q;
  logic                 hold_valid, hold_kind;
  logic [OP_W-1:0]      hold_op;
  logic [WKW-1:0]       stop_left;

  // decode
  logic              accept, op_ok, slot_ok;
  logic [OPW-1:0]    op_a;
  logic [CW-1:0]     succ_sat, cnt_sat;
  logic [DONE_W-1:0] done_inc;
  logic [WKW-1:0]    workers_clamped;
  logic              s_ok, push, done_walk;
  logic [OPW-1:0]    s_a;
  op_entry_t         entry_cur;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign op_ok   = (32'(op_index) < MAX_OPS);
  assign slot_ok = (32'(successor_slot) < MAX_SUCC);
  assign op_a    = OPW'(op_index);
  assign succ_sat = (32'(successor_total) > MAX_SUCC) ? CW'(MAX_SUCC) : CW'(successor_total);
  assign cnt_sat  = (32'(op_rdata.succ) > MAX_SUCC) ? CW'(MAX_SUCC) : op_rdata.succ;
  assign done_inc = (done_count == '1) ? done_count : done_count + DONE_W'(1);

  always_comb begin
    if (worker_cnt == '0) begin
      workers_clamped = WKW'(1);
    end else if (32'(worker_cnt) > MAX_WORKERS) begin
      workers_clamped = WKW'(MAX_WORKERS);
    end else begin
      workers_clamped = WKW'(worker_cnt);
    end
  end

  // walk pipeline: table read -> pending read -> decrement and write back
  assign s_ok = (32'(tab_rdata) < MAX_OPS);
  assign s_a  = OPW'(tab_rdata);
  // the write of the previous cycle is not yet visible to a read issued in that cycle
  assign entry_cur = (wr_valid_q && (wr_addr_q == p_addr)) ? wr_data_q : op_rdata;
  assign push      = pvalid && (entry_cur.pending == DEP_W'(1));
  assign done_walk = (issue_idx == cnt) && !tvalid && !pvalid;

  always_comb begin
    op_rd_en    = 1'b0;
    op_rd_addr  = op_a;
    op_we       = 1'b0;
    op_wr_addr  = op_a;
    op_wr_data  = '{pending: initial_dependencies, succ: succ_sat};
    tab_rd_en   = 1'b0;
    tab_rd_addr = {cur_op, SW'(issue_idx)};
    tab_we      = 1'b0;
    tab_wr_addr = {op_a, SW'(successor_slot)};
    case (state)
      S_IDLE: begin
        if (accept && op_ok) begin
          case (kind)
            KIND_LOAD_OP:   op_we = 1'b1;
            KIND_LOAD_SUCC: tab_we = slot_ok;
            KIND_COMPLETE:  op_rd_en = !halted;
            default: ;
          endcase
        end
      end
      S_WALK: begin
        tab_rd_en = (issue_idx < cnt);
        if (tvalid && s_ok) begin
          op_rd_en   = 1'b1;
          op_rd_addr = s_a;
        end
        if (pvalid && (entry_cur.pending != '0)) begin
          op_we      = 1'b1;
          op_wr_addr = p_addr;
          op_wr_data = '{pending: entry_cur.pending - DEP_W'(1), succ: entry_cur.succ};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op_we) begin
      op_mem[op_wr_addr] <= op_wr_data;
    end
    if (op_rd_en) begin
      op_rdata <= op_mem[op_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wr_addr] <= successor_op;
    end
    if (tab_rd_en) begin
      tab_rdata <= tab_mem[tab_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      strobe       <= 1'b0;
      hold_valid   <= 1'b0;
      tvalid       <= 1'b0;
      pvalid       <= 1'b0;
      wr_valid_q   <= 1'b0;
      done_count   <= '0;
      failure_code <= '0;
      halted       <= 1'b0;
      end_run      <= 1'b0;
      op_goal      <= TOTAL_OPS_RESET;
      worker_cnt   <= WORKER_COUNT_RESET;
    end else begin
      strobe     <= 1'b0;
      tvalid     <= 1'b0;
      pvalid     <= 1'b0;
      wr_valid_q <= op_we;
      wr_addr_q  <= op_wr_addr;
      wr_data_q  <= op_wr_data;

      if (cfg_write) begin
        case (cfg_index)
          REG_TOTAL_OPS:    op_goal    <= DONE_W'(cfg_data);
          REG_WORKER_COUNT: worker_cnt <= WORKERS_W'(cfg_data);
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept && op_ok) begin
            case (kind)
              KIND_LOAD_OP: begin
                if (initial_dependencies == '0) begin
                  strobe     <= 1'b1;
                  out_kind   <= OUT_READY;
                  ready_op   <= op_index;
                  run_status <= failure_code;
                  last       <= 1'b1;
                end
              end
              KIND_COMPLETE: begin
                if (!halted) begin
                  if (kernel_status != '0) begin
                    failure_code <= kernel_status;
                  end
                  done_count <= done_inc;
                  end_run    <= (done_inc >= op_goal) || (kernel_status != '0) ||
                                (failure_code != '0);
                  halted     <= (done_inc >= op_goal) || (kernel_status != '0) ||
                                (failure_code != '0);
                  cur_op     <= op_a;
                  state      <= S_CNT;
                end
              end
              default: ;
            endcase
          end
        end
        S_CNT: begin
          cnt       <= cnt_sat;
          issue_idx <= '0;
          state     <= S_WALK;
        end
        S_WALK: begin
          tvalid <= tab_rd_en;
          if (tab_rd_en) begin
            issue_idx <= issue_idx + CW'(1);
          end
          pvalid <= tvalid && s_ok;
          p_addr <= s_a;
          // results go through a one-deep hold so the final one can be flagged last
          if (push) begin
            if (hold_valid) begin
              strobe     <= 1'b1;
              out_kind   <= hold_kind;
              ready_op   <= hold_op;
              run_status <= failure_code;
              last       <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_kind  <= OUT_READY;
            hold_op    <= OP_W'(p_addr);
          end
          if (done_walk) begin
            if (end_run) begin
              stop_left <= workers_clamped;
              state     <= S_STOP;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_STOP: begin
          if (hold_valid) begin
            strobe     <= 1'b1;
            out_kind   <= hold_kind;
            ready_op   <= hold_op;
            run_status <= failure_code;
            last       <= 1'b0;
          end
          hold_valid <= 1'b1;
          hold_kind  <= OUT_STOP;
          hold_op    <= '0;
          stop_left  <= stop_left - WKW'(1);
          if (stop_left == WKW'(1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (hold_valid) begin
            strobe     <= 1'b1;
            out_kind   <= hold_kind;
            ready_op   <= hold_op;
            run_status <= failure_code;
            last       <= 1'b1;
          end
          hold_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/dds_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
module dds_checker #(
  parameter int MAX_OPS = dds_pkg::DEF_MAX_OPS
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [dds_pkg::KIND_W-1:0]  kind,
  input logic [dds_pkg::OP_W-1:0]    op_index,
  input logic [dds_pkg::DEP_W-1:0]   initial_dependencies,
  input logic                        strobe,
  input logic                        out_kind,
  input logic [dds_pkg::OP_W-1:0]    ready_op,
  input logic                        last
);
  import dds_pkg::*;

  // stop markers always carry operation zero
  a_stop_op_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && (out_kind == OUT_STOP) |-> (ready_op == '0))
    else $error("stop marker with nonzero operation");

  // a load with no dependencies is reported ready in the next cycle as a single result
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == KIND_LOAD_OP) && (initial_dependencies == '0) &&
    (32'(op_index) < MAX_OPS)
    |=> strobe && last && (out_kind == OUT_READY) && (ready_op == $past(op_index)))
    else $error("zero-dependency load not reported ready");

  // a completion request never produces a result in the cycle right after it
  a_complete_gap: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == KIND_COMPLETE) |=> !strobe)
    else $error("result too early after completion request");

  // stop markers come out back to back until the last one
  a_stop_run: assert property (@(posedge clk) disable iff (rst)
    strobe && (out_kind == OUT_STOP) && !last |=> strobe && (out_kind == OUT_STOP))
    else $error("gap in stop marker sequence");

endmodule

bind dag_dependency_scheduler_core dds_checker #(.MAX_OPS(MAX_OPS)) u_dds_checker (
  .clk                  (clk),
  .rst                  (rst),
  .start                (start),
  .busy                 (busy),
  .kind                 (kind),
  .op_index             (op_index),
  .initial_dependencies (initial_dependencies),
  .strobe               (strobe),
  .out_kind             (out_kind),
  .ready_op             (ready_op),
  .last                 (last)
);
